// File: hw/rtl/fbcm_pkg.sv
package fbcm_pkg;

	localparam int unsigned BLOCK_W = 16;
	localparam int unsigned HALF_W  = 8;
	localparam int unsigned KEYS_W  = 64;
	localparam int unsigned CFG_W   = 64;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned RCNT_W  = 4;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CBC = 2'd1,
		MODE_CFB = 2'd2,
		MODE_OFB = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ROUND_KEYS  = 3'd0,
		REG_ROUND_COUNT = 3'd1,
		REG_CIPHER_MODE = 3'd2,
		REG_DIRECTION   = 3'd3,
		REG_INIT_VECTOR = 3'd4
	} reg_idx_t;

	localparam logic [RCNT_W-1:0] ROUND_COUNT_RST = 4'd8;

	// Control for one pass through the round network.
	typedef struct packed {
		logic [RCNT_W-1:0] rounds;
		logic              dec;
	} cipher_ctl_t;

	// High nibble: ((3^h mod 17) + 2) mod 16.
	localparam logic [3:0] SBOX_HI [16] = '{
		4'd3, 4'd5, 4'd11, 4'd12, 4'd15, 4'd7, 4'd1, 4'd13,
		4'd2, 4'd0, 4'd10, 4'd9, 4'd6, 4'd14, 4'd4, 4'd8
	};

	// Low nibble: ((5^l mod 17) + 7) mod 16.
	localparam logic [3:0] SBOX_LO [16] = '{
		4'd8, 4'd12, 4'd15, 4'd13, 4'd4, 4'd5, 4'd9, 4'd1,
		4'd7, 4'd3, 4'd0, 4'd2, 4'd11, 4'd10, 4'd6, 4'd14
	};

	function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] x);
		logic [HALF_W-1:0] s;
		s = {SBOX_HI[x[7:4]], SBOX_LO[x[3:0]]};
		return {s[4:0], s[7:5]};
	endfunction

endpackage

// File: hw/rtl/fbcm_core.sv
module fbcm_core
	import fbcm_pkg::*;
#(
	parameter int unsigned MAX_ROUNDS = 8
) (
	input  logic [BLOCK_W-1:0] blk,
	input  logic [KEYS_W-1:0]  keys,
	input  cipher_ctl_t        ctl,
	output logic [BLOCK_W-1:0] res
);

	logic [HALF_W-1:0] lh [MAX_ROUNDS+1];
	logic [HALF_W-1:0] rh [MAX_ROUNDS+1];
	logic [RCNT_W-1:0] n_eff;

	// Round counts above the unrolled depth saturate; zero leaves the block unchanged.
	assign n_eff = (ctl.rounds > RCNT_W'(MAX_ROUNDS)) ? RCNT_W'(MAX_ROUNDS) : ctl.rounds;

	assign lh[0] = blk[15:8];
	assign rh[0] = blk[7:0];

	// Position j applies key j when encrypting and key MAX_ROUNDS-1-j when
	// decrypting; a position whose key index is at or past the round count passes through.
	for (genvar j = 0; j < MAX_ROUNDS; j++) begin : g_round
		localparam int unsigned KE = j;
		localparam int unsigned KD = MAX_ROUNDS - 1 - j;
		logic [HALF_W-1:0] key;
		logic              active;

		assign key    = ctl.dec ? keys[HALF_W*KD +: HALF_W] : keys[HALF_W*KE +: HALF_W];
		assign active = ctl.dec ? (RCNT_W'(KD) < n_eff) : (RCNT_W'(KE) < n_eff);

		always_comb begin
			if (!active) begin
				lh[j+1] = lh[j];
				rh[j+1] = rh[j];
			end else if (ctl.dec) begin
				lh[j+1] = rh[j] ^ round_f(lh[j] ^ key);
				rh[j+1] = lh[j];
			end else begin
				lh[j+1] = rh[j];
				rh[j+1] = lh[j] ^ round_f(rh[j] ^ key);
			end
		end
	end

	assign res = {lh[MAX_ROUNDS], rh[MAX_ROUNDS]};

endmodule

// File: hw/rtl/feistel_block_cipher_modes_unit.sv
// A block is captured in the input register, and its result is offered from the result
// register. Throughput: one block per cycle while out_ready keeps the output draining; the
// round network is unrolled between the input register and the result register, and the
// chaining register updates as each block moves into the result register.
// Reset: arst_n clears the pipeline valids and the chaining value and returns the
// configuration registers to their defaults (eight rounds, ECB, encrypt, zero keys and IV).
module feistel_block_cipher_modes_unit
	import fbcm_pkg::*;
#(
	parameter int unsigned MAX_ROUNDS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [HALF_W-1:0] block_hi,
	input  logic [HALF_W-1:0] block_lo,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [HALF_W-1:0] out_hi,
	output logic [HALF_W-1:0] out_lo
);

	logic [KEYS_W-1:0]  round_keys_q;
	logic [RCNT_W-1:0]  round_count_q;
	mode_t              cipher_mode_q;
	logic               direction_q;
	logic [BLOCK_W-1:0] init_vector_q;
	logic [BLOCK_W-1:0] chain_q;

	logic               valid_s1;
	logic [BLOCK_W-1:0] blk_s1;
	logic               restart_s1;

	logic               out_valid_q;
	logic [BLOCK_W-1:0] res_q;

	logic               advance;
	logic [BLOCK_W-1:0] cur_chain;
	logic [BLOCK_W-1:0] core_in;
	logic [BLOCK_W-1:0] core_out;
	logic [BLOCK_W-1:0] res_d;
	logic [BLOCK_W-1:0] chain_d;
	cipher_ctl_t        ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_keys_q  <= '0;
			round_count_q <= ROUND_COUNT_RST;
			cipher_mode_q <= MODE_ECB;
			direction_q   <= 1'b0;
			init_vector_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROUND_KEYS:  round_keys_q  <= cfg_data[KEYS_W-1:0];
				REG_ROUND_COUNT: round_count_q <= cfg_data[RCNT_W-1:0];
				REG_CIPHER_MODE: cipher_mode_q <= mode_t'(cfg_data[1:0]);
				REG_DIRECTION:   direction_q   <= cfg_data[0];
				REG_INIT_VECTOR: init_vector_q <= cfg_data[BLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	// The input stage moves on whenever the result register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blk_s1     <= {block_hi, block_lo};
			restart_s1 <= restart;
		end
	end

	assign cur_chain = restart_s1 ? init_vector_q : chain_q;

	// Feedback modes always run the forward cipher; only ECB and CBC decrypt.
	always_comb begin
		ctl.rounds = round_count_q;
		ctl.dec    = direction_q;
		core_in    = blk_s1;
		case (cipher_mode_q)
			MODE_CBC: begin
				core_in = direction_q ? blk_s1 : (blk_s1 ^ cur_chain);
			end
			MODE_CFB, MODE_OFB: begin
				ctl.dec = 1'b0;
				core_in = cur_chain;
			end
			default: ;
		endcase
	end

	fbcm_core #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) u_core (
		.blk (core_in),
		.keys(round_keys_q),
		.ctl (ctl),
		.res (core_out)
	);

	always_comb begin
		res_d   = core_out;
		chain_d = cur_chain;
		case (cipher_mode_q)
			MODE_CBC: begin
				if (direction_q) begin
					res_d   = core_out ^ cur_chain;
					chain_d = blk_s1;
				end else begin
					chain_d = core_out;
				end
			end
			MODE_CFB: begin
				res_d   = core_out ^ blk_s1;
				chain_d = direction_q ? blk_s1 : res_d;
			end
			MODE_OFB: begin
				res_d   = core_out ^ blk_s1;
				chain_d = core_out;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				chain_q <= chain_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hi    = res_q[15:8];
	assign out_lo    = res_q[7:0];

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("block left the input stage without reaching the result register");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(blk_s1))
		else $error("stalled input stage lost its block");

	a_ecb_chain_kept: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cipher_mode_q == MODE_ECB && !restart_s1 |=> $stable(chain_q))
		else $error("chaining value changed in ECB mode");

endmodule

// File: sim/fbcm_cipher_checker.sv
module fbcm_cipher_checker
	import fbcm_pkg::*;
#(
	parameter int unsigned MAX_ROUNDS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [HALF_W-1:0] block_hi,
	input  logic [HALF_W-1:0] block_lo,
	input  logic              restart,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [HALF_W-1:0] out_hi,
	input  logic [HALF_W-1:0] out_lo,
	output int                mismatches,
	output int                blocks_outstanding
);

	typedef struct packed {
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
	} block_t;

	block_t expected_blocks[$];

	// Shadow copy of the configuration and the chaining register.
	logic [KEYS_W-1:0]  keys;
	logic [RCNT_W-1:0]  rounds;
	mode_t              mode;
	logic               decrypt;
	logic [BLOCK_W-1:0] iv;
	logic [BLOCK_W-1:0] chain;

	function automatic int pow_mod17(input int base, input int e);
		int r;
		r = 1;
		for (int i = 0; i < e; i++)
			r = (r * base) % 17;
		return r;
	endfunction

	function automatic logic [HALF_W-1:0] mix_byte(input logic [HALF_W-1:0] x);
		logic [3:0]        h;
		logic [3:0]        l;
		logic [HALF_W-1:0] s;
		h = 4'((pow_mod17(3, int'(x[7:4])) + 2) % 16);
		l = 4'((pow_mod17(5, int'(x[3:0])) + 7) % 16);
		s = {h, l};
		return {s[4:0], s[7:5]};
	endfunction

	function automatic int active_rounds();
		return (rounds > MAX_ROUNDS) ? int'(MAX_ROUNDS) : int'(rounds);
	endfunction

	function automatic logic [BLOCK_W-1:0] encrypt16(input logic [BLOCK_W-1:0] blk);
		logic [HALF_W-1:0] l;
		logic [HALF_W-1:0] r;
		logic [HALF_W-1:0] t;
		int                n;
		l = blk[15:8];
		r = blk[7:0];
		n = active_rounds();
		for (int i = 0; i < n; i++) begin
			t = l ^ mix_byte(r ^ keys[8*i +: 8]);
			l = r;
			r = t;
		end
		return {l, r};
	endfunction

	function automatic logic [BLOCK_W-1:0] decrypt16(input logic [BLOCK_W-1:0] blk);
		logic [HALF_W-1:0] l;
		logic [HALF_W-1:0] r;
		logic [HALF_W-1:0] t;
		int                n;
		int                k;
		l = blk[15:8];
		r = blk[7:0];
		n = active_rounds();
		for (int i = 0; i < n; i++) begin
			k = n - 1 - i;
			t = r ^ mix_byte(l ^ keys[8*k +: 8]);
			r = l;
			l = t;
		end
		return {l, r};
	endfunction

	// Works out the result of one block and advances the chaining register.
	function automatic logic [BLOCK_W-1:0] cipher_step(input logic [BLOCK_W-1:0] p,
			input logic reload);
		logic [BLOCK_W-1:0] res;
		if (reload)
			chain = iv;
		case (mode)
			MODE_CBC: begin
				if (!decrypt) begin
					res = encrypt16(p ^ chain);
					chain = res;
				end else begin
					res = decrypt16(p) ^ chain;
					chain = p;
				end
			end
			MODE_CFB: begin
				res = encrypt16(chain) ^ p;
				chain = decrypt ? p : res;
			end
			MODE_OFB: begin
				chain = encrypt16(chain);
				res = p ^ chain;
			end
			default: begin
				res = decrypt ? decrypt16(p) : encrypt16(p);
			end
		endcase
		return res;
	endfunction

	always @(posedge clk) begin
		block_t want;
		if (!arst_n) begin
			keys = '0;
			rounds = ROUND_COUNT_RST;
			mode = MODE_ECB;
			decrypt = 1'b0;
			iv = '0;
			chain = '0;
			mismatches = 0;
			expected_blocks.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROUND_KEYS:  keys = cfg_data[KEYS_W-1:0];
					REG_ROUND_COUNT: rounds = cfg_data[RCNT_W-1:0];
					REG_CIPHER_MODE: mode = mode_t'(cfg_data[1:0]);
					REG_DIRECTION:   decrypt = cfg_data[0];
					REG_INIT_VECTOR: iv = cfg_data[BLOCK_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_blocks.push_back(block_t'(cipher_step({block_hi, block_lo}, restart)));
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					$display("%0t: result %02h%02h with no block outstanding",
						$time, out_hi, out_lo);
					mismatches++;
				end else begin
					want = expected_blocks.pop_front();
					if (out_hi !== want.hi) begin
						$display("%0t: out_hi expected %02h actual %02h", $time, want.hi, out_hi);
						mismatches++;
					end
					if (out_lo !== want.lo) begin
						$display("%0t: out_lo expected %02h actual %02h", $time, want.lo, out_lo);
						mismatches++;
					end
				end
			end
		end
		blocks_outstanding = expected_blocks.size();
	end

endmodule

// File: sim/feistel_block_cipher_modes_unit_tb.sv
module feistel_block_cipher_modes_unit_tb;
	import fbcm_pkg::*;

	localparam int RANDOM_BLOCKS = 800;
	localparam int STALL_LIMIT   = 1000;
	localparam int DRAIN_CYCLES  = 8;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [HALF_W-1:0] block_hi;
	logic [HALF_W-1:0] block_lo;
	logic              restart;
	logic              out_valid;
	logic              out_ready;
	logic [HALF_W-1:0] out_hi;
	logic [HALF_W-1:0] out_lo;

	int   mismatches;
	int   blocks_outstanding;
	int   stall_cycles = 0;
	int   random_sent;
	logic steady;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	feistel_block_cipher_modes_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.block_hi  (block_hi),
		.block_lo  (block_lo),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_hi    (out_hi),
		.out_lo    (out_lo)
	);

	fbcm_cipher_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.block_hi           (block_hi),
		.block_lo           (block_lo),
		.restart            (restart),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.out_hi             (out_hi),
		.out_lo             (out_lo),
		.mismatches         (mismatches),
		.blocks_outstanding (blocks_outstanding)
	);

	// Mostly short gaps, now and then a long one; none at all in steady phases.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [HALF_W-1:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
			input logic reload);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		block_hi <= hi;
		block_lo <= lo;
		restart <= reload;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops input and waits until every expected block has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (blocks_outstanding != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] keys, input logic [CFG_W-1:0] count,
			input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] dir,
			input logic [CFG_W-1:0] iv, input logic poke_unmapped);
		settle();
		write_reg(REG_ROUND_KEYS, keys);
		write_reg(REG_ROUND_COUNT, count);
		write_reg(REG_CIPHER_MODE, mode);
		write_reg(REG_DIRECTION, dir);
		write_reg(REG_INIT_VECTOR, iv);
		if (poke_unmapped)
			write_reg(REG_UNMAPPED_FIRST + IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return CFG_W'($urandom_range(9, 15));
		if (r == 2)
			return {$urandom, $urandom};
		return CFG_W'($urandom_range(1, 8));
	endfunction

	function automatic logic [CFG_W-1:0] pick_keys();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Receiver: random stalls in bursts.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, stall_cycles);
				$display("status: fail");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		mode_t mode;
		int    phase_len;
		logic  chained;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		block_hi = '0;
		block_lo = '0;
		restart = 1'b0;
		steady = 1'b0;
		random_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: eight rounds, zero keys, ECB encrypt.
		send_block(8'h00, 8'h00, 1'b0);
		send_block(8'hFF, 8'hFF, 1'b1);
		send_block(8'h80, 8'h01, 1'b0);

		// A zero round count passes blocks through unchanged.
		apply_config('1, '0, CFG_W'(MODE_ECB), '0, '0, 1'b0);
		send_block(8'h12, 8'h34, 1'b0);
		send_block(8'hA5, 8'h5A, 1'b0);

		// Round count of fifteen saturates; high data bits are masked off.
		apply_config(64'h0123_4567_89AB_CDEF, '1, {62'h2AAA_AAAA_AAAA_AAA8, MODE_ECB}, '1,
			'1, 1'b1);
		send_block(8'hFF, 8'h00, 1'b0);
		send_block(8'h00, 8'hFF, 1'b0);

		for (int m = MODE_CBC; m <= MODE_OFB; m++) begin
			for (int d = 0; d < 2; d++) begin
				mode = mode_t'(m);
				apply_config({$urandom, $urandom}, (d == 0) ? CFG_W'(1) : CFG_W'(8),
					CFG_W'(mode), CFG_W'(d), {48'hFFFF_0000_FFFF, 16'hFFFF}, 1'b0);
				send_block(pick_byte(), pick_byte(), 1'b1);
				send_block(pick_byte(), pick_byte(), 1'b0);
			end
		end

		while (random_sent < RANDOM_BLOCKS) begin
			mode = mode_t'($urandom_range(0, 3));
			chained = (mode != MODE_ECB);
			apply_config(pick_keys(), pick_count(), CFG_W'(mode), CFG_W'($urandom_range(0, 1)),
				{$urandom, $urandom}, ($urandom_range(0, 4) == 0));
			steady = ($urandom_range(0, 4) == 0);
			phase_len = $urandom_range(10, 60);
			for (int i = 0; i < phase_len; i++) begin
				// Chained streams normally open with a restart from the IV.
				send_block(pick_byte(), pick_byte(),
					(i == 0 && chained && $urandom_range(0, 7) != 0) ||
					($urandom_range(0, 11) == 0));
				random_sent++;
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && blocks_outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/fbcm_pkg.sv
hw/rtl/fbcm_core.sv
hw/rtl/feistel_block_cipher_modes_unit.sv
sim/fbcm_cipher_checker.sv
sim/feistel_block_cipher_modes_unit_tb.sv
